// ----- rtl/core/stex_pkg.sv -----
package stex_pkg;

  localparam int unsigned TILE_W  = 14;
  localparam int unsigned COLOR_W = 7;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned MAG_W   = 9;
  localparam int unsigned DIM_W   = 3;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned BANK_W  = 6;

  // attr_word bit positions
  localparam int unsigned ATTR_EN_BIT = 15;
  localparam int unsigned ATTR_FX_BIT = 14;
  localparam int unsigned ATTR_FY_BIT = 13;
  localparam int unsigned ATTR_W_LSB  = 10;
  localparam int unsigned ATTR_H_LSB  = 7;

  localparam int unsigned TILE_PRIO_LSB = 14;
  localparam int unsigned COORD_SIGN_BIT = 15;

  localparam logic [POS_W-1:0]   COORD_OFFSET = 11'h200;
  localparam logic [COLOR_W-1:0] COLOR_BASE   = 7'h40;

  typedef struct packed {
    logic load;   // input beat accepted
    logic step;   // emit one placement into the output register
  } stex_cmd_t;

  typedef struct packed {
    logic pass;   // presented entry is enabled and matches the pass priority
    logic last;   // current placement is the entry's final one
  } stex_sts_t;

endpackage

// ----- rtl/core/stex_ctrl.sv -----
module stex_ctrl
  import stex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  stex_sts_t sts,
  output stex_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready = (state_r == IDLE);
    cmd.load = in_valid && in_ready;
    // output slot is free, or is being emptied this cycle
    cmd.step = (state_r == RUN) && (!out_valid_r || out_ready);

    state_nxt = state_r;
    case (state_r)
      IDLE: begin
        if (cmd.load && sts.pass) state_nxt = RUN;
      end
      RUN: begin
        if (cmd.step && sts.last) state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase

    if (cmd.step)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE) |-> !cmd.step)
    else $error("placement emitted while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last) |=> (state_r == IDLE))
    else $error("expansion continued past last placement");

  a_drop_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.pass) |=> (state_r == IDLE))
    else $error("rejected entry started an expansion");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r)
    else $error("emitted placement not marked valid");

endmodule

// ----- rtl/core/stex_dpath.sv -----
module stex_dpath
  import stex_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [PRIO_W-1:0]       cfg_data,
  input  logic [15:0]             in_attr_word,
  input  logic [15:0]             in_tile_word,
  input  logic [15:0]             in_x_word,
  input  logic [15:0]             in_y_word,
  input  stex_cmd_t               cmd,
  output stex_sts_t               sts,
  output logic [TILE_W-1:0]       out_tile_code,
  output logic [COLOR_W-1:0]      out_color_code,
  output logic                    out_flip_horizontal,
  output logic                    out_flip_vertical,
  output logic signed [POS_W-1:0] out_x_pos,
  output logic signed [POS_W-1:0] out_y_pos,
  output logic                    out_last_tile
);

  logic [PRIO_W-1:0]  prio_r;
  logic [POS_W-1:0]   x0_r, y0_r;
  logic [BANK_W-1:0]  bank_r;
  logic               fx_r, fy_r;
  logic [DIM_W-1:0]   wm1_r, hm1_r;
  logic [DIM_W-1:0]   col_r, row_r, col_nxt, row_nxt;
  logic [TILE_W-1:0]  tile_r;

  logic [TILE_W-1:0]  o_tile_r;
  logic [COLOR_W-1:0] o_color_r;
  logic               o_fx_r, o_fy_r, o_last_r;
  logic [POS_W-1:0]   o_x_r, o_y_r;

  logic [DIM_W-1:0]   colpos;
  logic [POS_W-1:0]   x_cur, y_cur, x_dec, y_dec;

  function automatic logic [POS_W-1:0] decode_coord(input logic [15:0] w);
    logic [POS_W-1:0] mag;
    mag = {{(POS_W-MAG_W){1'b0}}, w[MAG_W-1:0]};
    return w[COORD_SIGN_BIT] ? (mag - COORD_OFFSET) : mag;
  endfunction

  always_comb begin
    sts.pass = in_attr_word[ATTR_EN_BIT]
            && (in_tile_word[TILE_PRIO_LSB +: PRIO_W] == prio_r);
    sts.last = (col_r == wm1_r) && (row_r == hm1_r);

    x_dec  = decode_coord(in_x_word);
    y_dec  = decode_coord(in_y_word);
    colpos = fx_r ? (wm1_r - col_r) : col_r;
    x_cur  = x0_r + {{(POS_W-DIM_W-4){1'b0}}, colpos, 4'b0000};
    y_cur  = y0_r + {{(POS_W-DIM_W-4){1'b0}}, row_r, 4'b0000};

    // rows inner, columns outer
    if (row_r == hm1_r) begin
      row_nxt = '0;
      col_nxt = col_r + 1'b1;
    end else begin
      row_nxt = row_r + 1'b1;
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
    end else if (cfg_valid) begin
      prio_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r   <= x_dec;
      y0_r   <= y_dec;
      bank_r <= in_attr_word[BANK_W-1:0];
      fx_r   <= in_attr_word[ATTR_FX_BIT];
      fy_r   <= in_attr_word[ATTR_FY_BIT];
      wm1_r  <= in_attr_word[ATTR_W_LSB +: DIM_W];
      hm1_r  <= in_attr_word[ATTR_H_LSB +: DIM_W];
      tile_r <= in_tile_word[TILE_W-1:0];
      col_r  <= '0;
      row_r  <= '0;
    end else if (cmd.step) begin
      tile_r <= tile_r + 1'b1;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      o_tile_r  <= tile_r;
      o_color_r <= {1'b0, bank_r} + COLOR_BASE;
      o_fx_r    <= fx_r;
      o_fy_r    <= fy_r;
      o_x_r     <= x_cur;
      o_y_r     <= y_cur;
      o_last_r  <= sts.last;
    end
  end

  assign out_tile_code       = o_tile_r;
  assign out_color_code      = o_color_r;
  assign out_flip_horizontal = o_fx_r;
  assign out_flip_vertical   = o_fy_r;
  assign out_x_pos           = o_x_r;
  assign out_y_pos           = o_y_r;
  assign out_last_tile       = o_last_r;

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (o_last_r == $past(sts.last)))
    else $error("last flag does not match counter position");

  a_tile_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !cmd.load) |=> (tile_r == $past(tile_r) + 1'b1))
    else $error("tile number did not advance");

endmodule

// ----- rtl/core/sprite_entry_tile_expander.sv -----
// Sprite entry tile expander.
// Input channel (in_valid/in_ready): one beat carries a four-word sprite
// entry. Entries that are disabled or whose priority differs from the
// configured pass priority are dropped and give no output; in_ready stays high.
// Output channel (out_valid/out_ready): one beat per tile placement,
// column-major, last_tile set on the final placement of the entry.
// Config channel (cfg_valid/cfg_ready): writes the pass priority; always
// ready, to be written only while the block is idle.
// The first placement is valid after the entry registers are loaded and
// the first step has written the output register. Throughput: one
// placement per cycle while out_ready is high, set by the single
// column/row counter pair; an entry of W by H tiles gives W*H placements,
// up to 64 for an 8 by 8 entry. The next entry is taken once the last
// placement sits in the output register, even if that placement is still
// waiting. When the receiver stalls, the output register holds its beat
// and the counters stop. Reset clears the pass priority to 0, empties the
// output register and returns the controller to idle.
module sprite_entry_tile_expander
  import stex_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PRIO_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             in_attr_word,
  input  logic [15:0]             in_tile_word,
  input  logic [15:0]             in_x_word,
  input  logic [15:0]             in_y_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TILE_W-1:0]       out_tile_code,
  output logic [COLOR_W-1:0]      out_color_code,
  output logic                    out_flip_horizontal,
  output logic                    out_flip_vertical,
  output logic signed [POS_W-1:0] out_x_pos,
  output logic signed [POS_W-1:0] out_y_pos,
  output logic                    out_last_tile
);

  stex_cmd_t cmd;
  stex_sts_t sts;

  assign cfg_ready = 1'b1;

  stex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stex_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_attr_word        (in_attr_word),
    .in_tile_word        (in_tile_word),
    .in_x_word           (in_x_word),
    .in_y_word           (in_y_word),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_tile_code       (out_tile_code),
    .out_color_code      (out_color_code),
    .out_flip_horizontal (out_flip_horizontal),
    .out_flip_vertical   (out_flip_vertical),
    .out_x_pos           (out_x_pos),
    .out_y_pos           (out_y_pos),
    .out_last_tile       (out_last_tile)
  );

endmodule
